// File: sv/hcbd_pkg.sv
// Shared types and constants for the chunked body decoder.
package hcbd_pkg;

  localparam int CHUNK_SIZE_BITS = 32;
  localparam logic [15:0] MAX_TRAILER_RESET = 16'd8192;

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_NEW   = 2'd2;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_SIZE    = 3'd1;
  localparam logic [2:0] ERR_TERM    = 3'd2;
  localparam logic [2:0] ERR_TRAILER = 3'd3;
  localparam logic [2:0] ERR_CLOSED  = 3'd4;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  localparam logic REG_MAX_TRAILER = 1'b0;

  typedef enum logic [2:0] {
    PH_SIZE    = 3'd0,
    PH_DATA    = 3'd1,
    PH_CRLF    = 3'd2,
    PH_TRAILER = 3'd3,
    PH_DONE    = 3'd4,
    PH_ERROR   = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    SS_LEAD   = 3'd0,
    SS_DIGITS = 3'd1,
    SS_TRAIL  = 3'd2,
    SS_EXT    = 3'd3,
    SS_BAD    = 3'd4
  } size_sub_t;

  typedef struct packed {
    size_sub_t                  sub;
    logic [CHUNK_SIZE_BITS-1:0] acc;
  } size_upd_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       body_done;
    logic       error_flag;
    logic [2:0] error_code;
  } result_t;

endpackage

// File: sv/hcbd_cfg.sv
// Configuration register block with APB-style access.
module hcbd_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] max_trailer
);
  import hcbd_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_trailer <= MAX_TRAILER_RESET;
    end else if (wr && paddr[2] == REG_MAX_TRAILER) begin
      max_trailer <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_TRAILER) ? {16'd0, max_trailer} : 32'd0;

endmodule

// File: sv/hcbd_core.sv
// Decoder state and the per-byte next-state logic.
module hcbd_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic [1:0]     command,
  input  logic [7:0]     data_byte,
  input  logic [15:0]    max_trailer,
  output hcbd_pkg::result_t res
);
  import hcbd_pkg::*;

  localparam int W = CHUNK_SIZE_BITS;

  phase_t     phase, phase_next;
  size_sub_t  sub, sub_next;
  logic       cr, cr_next;
  logic [W-1:0] acc, acc_next;
  logic [W-1:0] rem, rem_next;
  logic [15:0]  tcount, tcount_next;
  logic [2:0]   err, err_next;
  logic         pv;
  logic [7:0]   pb;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic size_upd_t size_char(input size_sub_t s, input logic [W-1:0] a,
                                          input logic [7:0] c);
    size_upd_t  u;
    logic       blank;
    logic [4:0] h;
    u.sub = s;
    u.acc = a;
    blank = (c == CH_SP) || (c == CH_TAB);
    h = hex_val(c);
    unique case (s)
      SS_LEAD, SS_DIGITS: begin
        if (c == CH_SEMI) begin
          u.sub = SS_EXT;
        end else if (h[4]) begin
          if (s == SS_DIGITS && a[W-1:W-4] != 4'd0) begin
            u.sub = SS_BAD;
          end else begin
            u.acc = {a[W-5:0], h[3:0]};
            u.sub = SS_DIGITS;
          end
        end else if (blank) begin
          if (s == SS_DIGITS) u.sub = SS_TRAIL;
        end else begin
          u.sub = SS_BAD;
        end
      end
      SS_TRAIL: begin
        if (c == CH_SEMI) u.sub = SS_EXT;
        else if (!blank) u.sub = SS_BAD;
      end
      default: begin
      end
    endcase
    return u;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SIZE;
      sub    <= SS_LEAD;
      cr     <= 1'b0;
      acc    <= '0;
      rem    <= '0;
      tcount <= 16'd0;
      err    <= ERR_NONE;
    end else begin
      phase  <= phase_next;
      sub    <= sub_next;
      cr     <= cr_next;
      acc    <= acc_next;
      rem    <= rem_next;
      tcount <= tcount_next;
      err    <= err_next;
    end
  end

  always_comb begin
    size_upd_t u;
    phase_next  = phase;
    sub_next    = sub;
    cr_next     = cr;
    acc_next    = acc;
    rem_next    = rem;
    tcount_next = tcount;
    err_next    = err;
    pv = 1'b0;
    pb = 8'd0;
    u.sub = sub;
    u.acc = acc;
    if (step) begin
      unique case (command)
        CMD_NEW: begin
          phase_next  = PH_SIZE;
          sub_next    = SS_LEAD;
          cr_next     = 1'b0;
          acc_next    = '0;
          rem_next    = '0;
          tcount_next = 16'd0;
          err_next    = ERR_NONE;
        end
        CMD_CLOSE: begin
          if (phase != PH_DONE && phase != PH_ERROR) begin
            phase_next = PH_ERROR;
            err_next   = ERR_CLOSED;
          end
        end
        CMD_BYTE: begin
          unique case (phase)
            PH_SIZE: begin
              if (cr && data_byte == CH_LF) begin
                if (sub == SS_BAD) begin
                  phase_next = PH_ERROR;
                  err_next   = ERR_SIZE;
                end else if (acc == '0) begin
                  phase_next  = PH_TRAILER;
                  tcount_next = 16'd0;
                end else begin
                  rem_next   = acc;
                  phase_next = PH_DATA;
                end
                cr_next  = 1'b0;
                sub_next = SS_LEAD;
                acc_next = '0;
              end else begin
                if (cr) u = size_char(u.sub, u.acc, CH_CR);
                if (data_byte == CH_CR) begin
                  cr_next = 1'b1;
                end else begin
                  cr_next = 1'b0;
                  u = size_char(u.sub, u.acc, data_byte);
                end
                sub_next = u.sub;
                acc_next = u.acc;
              end
            end
            PH_DATA: begin
              pv = 1'b1;
              pb = data_byte;
              rem_next = rem - {{(W-1){1'b0}}, 1'b1};
              if (rem_next == '0) begin
                phase_next = PH_CRLF;
                cr_next    = 1'b0;
                sub_next   = SS_LEAD;
              end
            end
            PH_CRLF: begin
              if (!cr) begin
                cr_next  = 1'b1;
                sub_next = (data_byte == CH_CR) ? SS_LEAD : SS_BAD;
              end else begin
                cr_next  = 1'b0;
                sub_next = SS_LEAD;
                if (sub == SS_BAD || data_byte != CH_LF) begin
                  phase_next = PH_ERROR;
                  err_next   = ERR_TERM;
                end else begin
                  phase_next = PH_SIZE;
                end
              end
            end
            PH_TRAILER: begin
              if (cr && data_byte == CH_LF) begin
                phase_next = PH_DONE;
                cr_next    = 1'b0;
              end else if (tcount >= max_trailer) begin
                phase_next = PH_ERROR;
                err_next   = ERR_TRAILER;
              end else begin
                tcount_next = tcount + 16'd1;
                cr_next     = (data_byte == CH_CR);
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assign res.payload_valid = pv;
  assign res.payload_byte  = pb;
  assign res.body_done     = (phase_next == PH_DONE);
  assign res.error_flag    = (err_next != ERR_NONE);
  assign res.error_code    = err_next;

endmodule

// File: sv/http_chunked_body_decoder_top.sv
// Top level of the HTTP/1.1 chunked body decoder.
// Takes one word per clock on s_axis (command in tuser, body byte in tdata) and gives
// exactly one status word per input word on m_axis, registered at the same edge that
// accepts the input word. The decoder state updates in one step from the accepted word
// into a one-deep output register, which can refill in the cycle it drains, so
// throughput is one word per clock whenever m_axis_tready is high. While a status word
// waits with m_axis_tready low, s_axis_tready drops and input stalls. Command 2
// restarts a body; the trailer limit is set through the APB port at address 0 and
// survives restarts.
module http_chunked_body_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [8] body_done,
                                      // [9] error_flag, [12:10] error_code
  output logic [0:0]  m_axis_tuser,   // [0] payload_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hcbd_pkg::*;

  logic        step;
  logic [15:0] max_trailer;
  result_t     res;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;

  hcbd_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_trailer (max_trailer)
  );

  hcbd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .command     (s_axis_tuser),
    .data_byte   (s_axis_tdata),
    .max_trailer (max_trailer),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_axis_tdata <= {3'd0, res.error_code, res.error_flag, res.body_done, res.payload_byte};
      m_axis_tuser <= res.payload_valid;
    end
  end

endmodule

// File: sv/hcbd_checker.sv
// Port-level checks for the chunked body decoder, bound to the top level.
module hcbd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_err_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[9] == (m_axis_tdata[12:10] != 3'd0)))
    else $error("error flag disagrees with error code");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[9:8] == 2'b00)
    else $error("payload word reports done or error");

  a_idle_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("payload byte nonzero without payload");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
